[rtl/assert_macros.svh]
// Assertion helpers for the checker file msa_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is held off while the given reset is asserted.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, using the standard clock and reset names of this project.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

[rtl/msa_pkg.sv]
package msa_pkg;

  localparam int MaxNodes    = 32;
  localparam int MaxVsources = 8;
  localparam int ValueWidth  = 32;

  localparam int ActW   = 3;
  localparam int NodeW  = 6;
  localparam int SrcW   = 3;
  localparam int DataW  = 32;
  localparam int StatW  = 2;
  localparam int StepW  = 3;

  localparam logic [NodeW-1:0] NodeCountReset = 6'd32;
  localparam logic [StepW-1:0] LastStep       = 3'd4;

  typedef enum logic [ActW-1:0] {
    ACT_CLEAR = 3'd0,
    ACT_ISRC  = 3'd1,
    ACT_RES   = 3'd2,
    ACT_VSRC  = 3'd3,
    ACT_READ  = 3'd4
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE     = 2'd0,
    ST_ZERO_RES = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  typedef struct packed {
    logic             clr_start;
    logic             clr_step;
    logic             accept;
    logic             div_start;
    logic             div_step;
    logic [StepW-1:0] step;
    logic             stamp_rd;
    logic             stamp_wr;
    logic             read_issue;
    logic             read_cap;
    logic             push;
  } msa_cmd_t;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic            bad;
    logic            step_en;
    logic            clr_last;
    logic            div_last;
  } msa_sts_t;

endpackage

[rtl/msa_if.sv]
interface msa_in_if;
  logic                             valid;
  logic                             ready;
  logic [msa_pkg::ActW-1:0]         action;
  logic [msa_pkg::NodeW-1:0]        node_a;
  logic [msa_pkg::NodeW-1:0]        node_b;
  logic signed [msa_pkg::DataW-1:0] value;
  logic [msa_pkg::SrcW-1:0]         source_index;
  logic [msa_pkg::NodeW-1:0]        read_row;
  logic [msa_pkg::NodeW-1:0]        read_col;

  modport source (output valid, action, node_a, node_b, value, source_index, read_row,
                  read_col, input ready);
  modport sink (input valid, action, node_a, node_b, value, source_index, read_row,
                read_col, output ready);
endinterface

interface msa_out_if;
  logic                             valid;
  logic                             ready;
  logic [msa_pkg::StatW-1:0]        status;
  logic signed [msa_pkg::DataW-1:0] coeff_entry;
  logic signed [msa_pkg::DataW-1:0] rhs_entry;

  modport source (output valid, status, coeff_entry, rhs_entry, input ready);
  modport sink (input valid, status, coeff_entry, rhs_entry, output ready);
endinterface

[rtl/msa_ram.sv]
module msa_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/msa_ctrl.sv]
module msa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  msa_pkg::msa_sts_t sts_i,
  output msa_pkg::msa_cmd_t cmd_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_STEP  = 4'd4;
  localparam logic [3:0] S_WR    = 4'd5;
  localparam logic [3:0] S_RDA   = 4'd6;
  localparam logic [3:0] S_RDB   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]                state_q, state_d;
  logic [msa_pkg::StepW-1:0] step_q, step_d;
  logic                      clr_item_q, clr_item_d;
  logic                      out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    clr_item_d = clr_item_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o      = '0;
    cmd_o.step = step_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = clr_item_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DISP;
        end
      end
      S_DISP: begin
        step_d = '0;
        if (sts_i.bad) begin
          state_d = S_DONE;
        end else begin
          unique case (sts_i.action)
            msa_pkg::ACT_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              clr_item_d      = 1'b1;
              state_d         = S_CLEAR;
            end
            msa_pkg::ACT_RES: begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
            msa_pkg::ACT_READ: state_d = S_RDA;
            msa_pkg::ACT_ISRC, msa_pkg::ACT_VSRC: state_d = S_STEP;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (sts_i.step_en) begin
          cmd_o.stamp_rd = 1'b1;
          state_d        = S_WR;
        end else if (step_q == msa_pkg::LastStep) begin
          state_d = S_DONE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_WR: begin
        cmd_o.stamp_wr = 1'b1;
        if (step_q == msa_pkg::LastStep) begin
          state_d = S_DONE;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = S_STEP;
        end
      end
      S_RDA: begin
        cmd_o.read_issue = 1'b1;
        state_d          = S_RDB;
      end
      S_RDB: begin
        cmd_o.read_cap = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.push  = 1'b1;
          out_valid_d = 1'b1;
          clr_item_d  = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      step_q      <= '0;
      clr_item_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      clr_item_q  <= clr_item_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/msa_dp.sv]
module msa_dp #(
  parameter int MAX_NODES    = msa_pkg::MaxNodes,
  parameter int MAX_VSOURCES = msa_pkg::MaxVsources,
  parameter int VALUE_WIDTH  = msa_pkg::ValueWidth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [msa_pkg::NodeW-1:0]        cfg_wdata_i,
  input  logic [msa_pkg::ActW-1:0]         action_i,
  input  logic [msa_pkg::NodeW-1:0]        node_a_i,
  input  logic [msa_pkg::NodeW-1:0]        node_b_i,
  input  logic signed [msa_pkg::DataW-1:0] value_i,
  input  logic [msa_pkg::SrcW-1:0]         source_index_i,
  input  logic [msa_pkg::NodeW-1:0]        read_row_i,
  input  logic [msa_pkg::NodeW-1:0]        read_col_i,
  output logic [msa_pkg::StatW-1:0]        status_o,
  output logic signed [msa_pkg::DataW-1:0] coeff_entry_o,
  output logic signed [msa_pkg::DataW-1:0] rhs_entry_o,
  input  msa_pkg::msa_cmd_t                cmd_i,
  output msa_pkg::msa_sts_t                sts_o
);

  localparam int Dim   = MAX_NODES + MAX_VSOURCES;
  localparam int Depth = Dim * Dim;
  localparam int RowW  = $clog2(Dim);
  localparam int AddrW = $clog2(Depth);
  localparam int CW    = RowW + msa_pkg::NodeW + 2;
  localparam int VW    = VALUE_WIDTH;
  localparam int AW    = VALUE_WIDTH + 34;
  localparam int OW    = VALUE_WIDTH + msa_pkg::DataW;
  localparam int QW    = msa_pkg::DataW + 1;
  localparam int DcW   = $clog2(QW);
  localparam int DW    = msa_pkg::DataW;

  function automatic logic [VW-1:0] clamp_vw(input logic signed [AW-1:0] x);
    logic [AW-VW:0] top;
    top = x[AW-1:VW-1];
    if ((&top) || !(|top)) begin
      return x[VW-1:0];
    end
    return x[AW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
  endfunction

  function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      return s[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end
    return s[VW-1:0];
  endfunction

  function automatic logic [DW-1:0] out_sat(input logic [VW-1:0] a);
    logic signed [OW-1:0] x;
    logic [OW-DW:0]       top;
    x   = OW'($signed(a));
    top = x[OW-1:DW-1];
    if ((&top) || !(|top)) begin
      return x[DW-1:0];
    end
    return x[OW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
  endfunction

  logic [msa_pkg::NodeW-1:0]        node_count_q;
  logic [msa_pkg::ActW-1:0]         act_q;
  logic [msa_pkg::NodeW-1:0]        na_q, nb_q, rr_q, rc_q;
  logic signed [DW-1:0]             val_q;
  logic [RowW-1:0]                  vrow_q;
  logic [msa_pkg::StatW-1:0]        stat_q, stat_d;
  logic [DW-1:0]                    ce_q, re_q;
  logic [msa_pkg::StatW-1:0]        ostat_q;
  logic [DW-1:0]                    oce_q, ore_q;
  logic [AddrW-1:0]                 clr_cnt_q;
  logic [QW-1:0]                    rem_q, quo_q;
  logic [DW-1:0]                    mag_q;
  logic [DcW-1:0]                   dcnt_q;

  logic [CW-1:0]                    nc, vrow;
  logic                             nbad;
  logic [QW-1:0]                    trial;
  logic signed [AW-1:0]             gx, gsat, valx, onex, addend;
  logic                             step_en, is_rhs;
  logic [RowW-1:0]                  sr, sc, ia, ib;
  logic [AddrW-1:0]                 c_raddr, c_waddr, c_wdata_addr;
  logic [RowW-1:0]                  r_raddr, r_waddr;
  logic [VW-1:0]                    c_rdata, r_rdata, c_wdata, r_wdata, add_vw;
  logic                             c_we, r_we;

  assign nc   = (CW'(node_count_q) > CW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(node_count_q);
  assign vrow = nc + CW'(source_index_i);
  assign nbad = (CW'(node_a_i) > nc) || (CW'(node_b_i) > nc);

  always_comb begin
    unique case (action_i)
      msa_pkg::ACT_CLEAR: stat_d = msa_pkg::ST_DONE;
      msa_pkg::ACT_ISRC:  stat_d = nbad ? msa_pkg::ST_RANGE : msa_pkg::ST_DONE;
      msa_pkg::ACT_RES: begin
        if (nbad) begin
          stat_d = msa_pkg::ST_RANGE;
        end else begin
          stat_d = (value_i == '0) ? msa_pkg::ST_ZERO_RES : msa_pkg::ST_DONE;
        end
      end
      msa_pkg::ACT_VSRC: begin
        stat_d = (nbad || (CW'(source_index_i) >= CW'(MAX_VSOURCES))
                  || (vrow >= CW'(Dim))) ? msa_pkg::ST_RANGE : msa_pkg::ST_DONE;
      end
      msa_pkg::ACT_READ: begin
        stat_d = ((CW'(read_row_i) >= CW'(Dim)) || (CW'(read_col_i) >= CW'(Dim)))
                 ? msa_pkg::ST_RANGE : msa_pkg::ST_DONE;
      end
      default: stat_d = msa_pkg::ST_RANGE;
    endcase
  end

  assign trial = {rem_q[QW-2:0], (dcnt_q == '0)};
  assign gx    = val_q[DW-1] ? -AW'($signed({1'b0, quo_q})) : AW'($signed({1'b0, quo_q}));
  assign gsat  = AW'($signed(clamp_vw(gx)));
  assign valx  = AW'(val_q);
  assign onex  = AW'(65536);
  assign ia    = RowW'(CW'(na_q) - CW'(1));
  assign ib    = RowW'(CW'(nb_q) - CW'(1));

  always_comb begin
    step_en = 1'b0;
    is_rhs  = 1'b0;
    sr      = ia;
    sc      = ia;
    addend  = valx;
    unique case (act_q)
      msa_pkg::ACT_ISRC: begin
        is_rhs = 1'b1;
        unique case (cmd_i.step)
          3'd0: step_en = (na_q != '0);
          3'd1: begin
            step_en = (nb_q != '0);
            sr      = ib;
            addend  = -valx;
          end
          default: step_en = 1'b0;
        endcase
      end
      msa_pkg::ACT_RES: begin
        addend = gsat;
        unique case (cmd_i.step)
          3'd0: step_en = (na_q != '0);
          3'd1: begin
            step_en = (nb_q != '0);
            sr      = ib;
            sc      = ib;
          end
          3'd2: begin
            step_en = (na_q != '0) && (nb_q != '0);
            sc      = ib;
            addend  = -gsat;
          end
          3'd3: begin
            step_en = (na_q != '0) && (nb_q != '0);
            sr      = ib;
            addend  = -gsat;
          end
          default: step_en = 1'b0;
        endcase
      end
      msa_pkg::ACT_VSRC: begin
        unique case (cmd_i.step)
          3'd0: begin
            step_en = (na_q != '0);
            sc      = vrow_q;
            addend  = onex;
          end
          3'd1: begin
            step_en = (na_q != '0);
            sr      = vrow_q;
            addend  = onex;
          end
          3'd2: begin
            step_en = (nb_q != '0);
            sr      = ib;
            sc      = vrow_q;
            addend  = -onex;
          end
          3'd3: begin
            step_en = (nb_q != '0);
            sr      = vrow_q;
            sc      = ib;
            addend  = -onex;
          end
          3'd4: begin
            step_en = 1'b1;
            is_rhs  = 1'b1;
            sr      = vrow_q;
          end
          default: step_en = 1'b0;
        endcase
      end
      default: step_en = 1'b0;
    endcase
  end

  assign add_vw       = clamp_vw(addend);
  assign c_wdata_addr = AddrW'(sr) * AddrW'(Dim) + AddrW'(sc);
  assign c_raddr      = cmd_i.read_issue
                        ? AddrW'(CW'(rr_q)) * AddrW'(Dim) + AddrW'(CW'(rc_q)) : c_wdata_addr;
  assign r_raddr      = cmd_i.read_issue ? RowW'(CW'(rr_q)) : sr;
  assign c_we         = cmd_i.clr_step || (cmd_i.stamp_wr && !is_rhs);
  assign r_we         = (cmd_i.clr_step && (clr_cnt_q < AddrW'(Dim)))
                        || (cmd_i.stamp_wr && is_rhs);
  assign c_waddr      = cmd_i.clr_step ? clr_cnt_q : c_wdata_addr;
  assign r_waddr      = cmd_i.clr_step ? RowW'(clr_cnt_q) : sr;
  assign c_wdata      = cmd_i.clr_step ? '0 : sat_add(c_rdata, add_vw);
  assign r_wdata      = cmd_i.clr_step ? '0 : sat_add(r_rdata, add_vw);

  msa_ram #(.Width(VW), .Depth(Depth)) u_coeff_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  msa_ram #(.Width(VW), .Depth(Dim)) u_rhs_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  assign sts_o.action   = act_q;
  assign sts_o.bad      = (stat_q != msa_pkg::ST_DONE);
  assign sts_o.step_en  = step_en;
  assign sts_o.clr_last = (clr_cnt_q == AddrW'(Depth - 1));
  assign sts_o.div_last = (dcnt_q == DcW'(QW - 1));

  assign status_o      = ostat_q;
  assign coeff_entry_o = oce_q;
  assign rhs_entry_o   = ore_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= msa_pkg::NodeCountReset;
      clr_cnt_q    <= '0;
      dcnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_start || (cmd_i.clr_step && sts_o.clr_last)) begin
        clr_cnt_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.div_start) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q  <= action_i;
      na_q   <= node_a_i;
      nb_q   <= node_b_i;
      val_q  <= value_i;
      rr_q   <= read_row_i;
      rc_q   <= read_col_i;
      vrow_q <= RowW'(vrow);
      stat_q <= stat_d;
      ce_q   <= '0;
      re_q   <= '0;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= '0;
      mag_q <= val_q[DW-1] ? (~val_q + 1'b1) : val_q;
    end else if (cmd_i.div_step) begin
      if (trial >= {1'b0, mag_q}) begin
        rem_q <= trial - {1'b0, mag_q};
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
    end
    if (cmd_i.read_cap) begin
      ce_q <= out_sat(c_rdata);
      re_q <= out_sat(r_rdata);
    end
    if (cmd_i.push) begin
      ostat_q <= stat_q;
      oce_q   <= ce_q;
      ore_q   <= re_q;
    end
  end

endmodule

[rtl/mna_stamp_accumulator.sv]
// Channel   Dir  Handshake     Beat contents
// item_i    in   valid/ready   action, node_a, node_b, value, source_index, read_row, read_col
// result_o  out  valid/ready   status, coeff_entry, rhs_entry
// cfg       in   cfg_we_i      node_count
//
// One item at a time. Each stamp of a current or voltage source is a read-modify-write on
// the matrix memory. A resistor first runs the bit-serial conductance divider, then its
// stamps. A read issues the memory read and then captures the entry. After reset, and for
// a clear item, a clearing pass walks all 1600 matrix entries, one per cycle, while item_i
// is not ready. The result register frees the next item while a beat waits on result_o.
module mna_stamp_accumulator #(
  parameter int MAX_NODES    = msa_pkg::MaxNodes,
  parameter int MAX_VSOURCES = msa_pkg::MaxVsources,
  parameter int VALUE_WIDTH  = msa_pkg::ValueWidth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [msa_pkg::NodeW-1:0] cfg_wdata_i,
  msa_in_if.sink                    item_i,
  msa_out_if.source                 result_o
);

  msa_pkg::msa_cmd_t cmd;
  msa_pkg::msa_sts_t sts;

  msa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  msa_dp #(
    .MAX_NODES    (MAX_NODES),
    .MAX_VSOURCES (MAX_VSOURCES),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .action_i       (item_i.action),
    .node_a_i       (item_i.node_a),
    .node_b_i       (item_i.node_b),
    .value_i        (item_i.value),
    .source_index_i (item_i.source_index),
    .read_row_i     (item_i.read_row),
    .read_col_i     (item_i.read_col),
    .status_o       (result_o.status),
    .coeff_entry_o  (result_o.coeff_entry),
    .rhs_entry_o    (result_o.rhs_entry),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

[rtl/msa_chk.sv]
`include "assert_macros.svh"

module msa_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [msa_pkg::StatW-1:0]        status_i,
  input logic signed [msa_pkg::DataW-1:0] coeff_entry_i,
  input logic signed [msa_pkg::DataW-1:0] rhs_entry_i
);

  `ASSERT_STD(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")
  `ASSERT_STD(a_stat_code, out_valid_i |-> status_i <= msa_pkg::ST_RANGE, "illegal status code")
  `ASSERT_STD(a_err_zero, out_valid_i && status_i != msa_pkg::ST_DONE |-> coeff_entry_i == 0 && rhs_entry_i == 0, "entries not zero on error")
  `ASSERT_STD(a_one_item, in_valid_i && in_ready_i |=> !in_ready_i, "second item taken while busy")

endmodule

bind mna_stamp_accumulator msa_chk u_msa_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (item_i.valid),
  .in_ready_i    (item_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .status_i      (result_o.status),
  .coeff_entry_i (result_o.coeff_entry),
  .rhs_entry_i   (result_o.rhs_entry)
);
